>>> rtl/core/uartfd_pkg.sv
// Shared types and constants for the UART receive frame delimiter.
`default_nettype none
package uartfd_pkg;

  localparam int unsigned BUFFER_BYTES  = 1024;
  localparam int unsigned TIMEOUT_LIMIT = 1000;

  localparam int unsigned LenW   = 11;  // frame length / byte count
  localparam int unsigned IdxW   = 10;  // byte position in frame
  localparam int unsigned IdleW  = 10;  // idle tick counter
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [LenW-1:0]  LEN_MAX     = LenW'(BUFFER_BYTES);
  localparam logic [IdleW-1:0] IDLE_MAX    = IdleW'(TIMEOUT_LIMIT);
  localparam logic [LenW-1:0]  LEN_RESET   = LenW'(1024);
  localparam logic [IdleW-1:0] TIMEOUT_RST = IdleW'(1000);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_TERM    = 2'd0,
    CAUSE_LENGTH  = 2'd1,
    CAUSE_TIMEOUT = 2'd2,
    CAUSE_FLUSH   = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_TERM_ENABLE  = 2'd1,
    REG_TERM_BYTE    = 2'd2,
    REG_TIMEOUT      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic            byte_valid;
    logic [7:0]      data_byte;
    logic [IdxW-1:0] byte_index;
    logic            frame_done;
    logic [LenW-1:0] frame_bytes;
    logic [1:0]      end_cause;
  } out_t;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic             terminator_enable;
    logic [7:0]       terminator_byte;
    logic [IdleW-1:0] timeout_ticks;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/uart_rx_frame_delimiter_unit.sv
// Top level of the UART receive frame delimiter.
// Takes one beat per cycle (received byte, time tick or flush request) and
// returns at most one result beat per input, in order. The result is held in
// an output register backed by a one-entry skid register, so input is stalled
// only when both are full; sustained rate is one item per clock while the
// output is not stalled, with no setup pass after reset. Bytes pass through
// with their frame position; frame ends report length and cause. Registers
// (4-byte stride): 0 frame_length, 1 terminator_enable, 2 terminator_byte,
// 3 timeout_ticks. Write them only while the block is idle.
`default_nettype none
module uart_rx_frame_delimiter_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire uartfd_pkg::in_t              in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output uartfd_pkg::out_t                  out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [uartfd_pkg::AddrW-1:0] paddr,
  input  wire logic [uartfd_pkg::DataW-1:0] pwdata,
  output logic      [uartfd_pkg::DataW-1:0] prdata,
  output logic                              pready
);
  import uartfd_pkg::*;

  cfg_t cfg;
  logic accept;
  logic res_valid;
  out_t res;

  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;
  logic out_pop;

  assign pready = 1'b1;

  uartfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  uartfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // skid full: no new beats, drain skid into output
      if (out_pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/core/uartfd_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module uartfd_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [uartfd_pkg::AddrW-1:0] paddr,
  input  wire logic [uartfd_pkg::DataW-1:0] pwdata,
  output logic      [uartfd_pkg::DataW-1:0] prdata,
  output uartfd_pkg::cfg_t              cfg_o
);
  import uartfd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e sel;

  assign wr_en = psel && penable && pwrite;
  assign sel   = reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_FRAME_LENGTH: cfg_d.frame_length      = pwdata[LenW-1:0];
        REG_TERM_ENABLE:  cfg_d.terminator_enable = pwdata[0];
        REG_TERM_BYTE:    cfg_d.terminator_byte   = pwdata[7:0];
        REG_TIMEOUT:      cfg_d.timeout_ticks     = pwdata[IdleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_FRAME_LENGTH: prdata[LenW-1:0]  = cfg_q.frame_length;
      REG_TERM_ENABLE:  prdata[0]         = cfg_q.terminator_enable;
      REG_TERM_BYTE:    prdata[7:0]       = cfg_q.terminator_byte;
      REG_TIMEOUT:      prdata[IdleW-1:0] = cfg_q.timeout_ticks;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length      <= LEN_RESET;
      cfg_q.terminator_enable <= 1'b0;
      cfg_q.terminator_byte   <= 8'd0;
      cfg_q.timeout_ticks     <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/uartfd_core.sv
// Frame tracking: fill count, idle counter and per-beat result logic.
`default_nettype none
module uartfd_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire uartfd_pkg::cfg_t cfg_i,
  input  wire logic             accept_i,
  input  wire uartfd_pkg::in_t  in_i,
  output logic                  res_valid_o,
  output uartfd_pkg::out_t      res_o
);
  import uartfd_pkg::*;

  logic [IdxW-1:0]  fill_q, fill_d;
  logic [IdleW-1:0] idle_q, idle_d;

  logic [LenW-1:0]  eff_len;
  logic [IdleW-1:0] eff_to;
  logic [LenW-1:0]  count;
  logic [IdleW-1:0] idle_inc;
  logic             term_hit;
  logic             len_hit;
  logic             frame_busy;

  always_comb begin
    if (cfg_i.frame_length == '0)          eff_len = LenW'(1);
    else if (cfg_i.frame_length > LEN_MAX) eff_len = LEN_MAX;
    else                                   eff_len = cfg_i.frame_length;
    eff_to = (cfg_i.timeout_ticks > IDLE_MAX) ? IDLE_MAX : cfg_i.timeout_ticks;
  end

  assign count      = {1'b0, fill_q} + LenW'(1);
  assign idle_inc   = (idle_q < IDLE_MAX) ? idle_q + IdleW'(1) : idle_q;
  assign term_hit   = cfg_i.terminator_enable && (in_i.rx_byte == cfg_i.terminator_byte);
  assign len_hit    = count >= eff_len;
  assign frame_busy = fill_q != '0;

  always_comb begin
    fill_d      = fill_q;
    idle_d      = idle_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (in_i.operation)
      OP_BYTE: begin
        res_valid_o      = 1'b1;
        idle_d           = '0;
        res_o.byte_valid = 1'b1;
        res_o.data_byte  = in_i.rx_byte;
        res_o.byte_index = fill_q;
        if (term_hit || len_hit) begin
          fill_d            = '0;
          res_o.frame_done  = 1'b1;
          res_o.frame_bytes = count;
          res_o.end_cause   = term_hit ? CAUSE_TERM : CAUSE_LENGTH;
        end else begin
          fill_d = count[IdxW-1:0];
        end
      end
      OP_TICK: begin
        idle_d = idle_inc;
        if (frame_busy && (idle_inc >= eff_to)) begin
          fill_d            = '0;
          res_valid_o       = 1'b1;
          res_o.frame_done  = 1'b1;
          res_o.frame_bytes = {1'b0, fill_q};
          res_o.end_cause   = CAUSE_TIMEOUT;
        end
      end
      OP_FLUSH: begin
        if (frame_busy) begin
          fill_d            = '0;
          res_valid_o       = 1'b1;
          res_o.frame_done  = 1'b1;
          res_o.frame_bytes = {1'b0, fill_q};
          res_o.end_cause   = CAUSE_FLUSH;
        end
      end
      default: ;  // unused opcode: no result, no state change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idle_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      idle_q <= idle_d;
    end
  end

endmodule
`default_nettype wire
